/* rtl/ttcs_pkg.sv */
package ttcs_pkg;

    // Input kinds carried in s_tuser.
    localparam logic [1:0] KIND_PUT   = 2'd0;
    localparam logic [1:0] KIND_CLEAR = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // Character codes with a meaning of their own.
    localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
    localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;

    // Attribute that the screen holds after reset, and color reset values.
    localparam logic [7:0] RESET_ATTR = 8'h07;
    localparam logic [3:0] RESET_FG   = 4'd7;
    localparam logic [3:0] RESET_BG   = 4'd0;

    // Field widths of the stream payloads.
    localparam int KIND_W    = 2;
    localparam int CHAR_W    = 8;
    localparam int IN_ROW_W  = 5;
    localparam int IN_COL_W  = 7;
    localparam int S_DATA_W  = 24;
    localparam int M_DATA_W  = 32;
    localparam int CELL_W    = 16;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR = 4'd1;

    // Modes of the store sweep engine.
    localparam logic [1:0] SWEEP_INIT   = 2'd0;
    localparam logic [1:0] SWEEP_CLEAR  = 2'd1;
    localparam logic [1:0] SWEEP_SCROLL = 2'd2;

    typedef struct packed {
        logic       in_load;
        logic       put;
        logic       bs_write;
        logic       next_row;
        logic       home;
        logic       sweep_start;
        logic [1:0] sweep_mode;
        logic       read_issue;
        logic       cell_capture;
        logic       out_load;
    } ttcs_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       is_bs;
        logic       is_nl;
        logic       col_last;
        logic       row_last;
        logic       sweep_busy;
        logic       out_free;
    } ttcs_status_t;

endpackage

/* rtl/ttcs_ram.sv */
module ttcs_ram
    #(
        parameter int WIDTH = 16,
        parameter int DEPTH = 2000,
        localparam int AW = $clog2(DEPTH)
    )
    (
        input  logic             aclk,
        input  logic             we,
        input  logic [AW-1:0]    waddr,
        input  logic [WIDTH-1:0] wdata,
        input  logic [AW-1:0]    raddr,
        output logic [WIDTH-1:0] rdata
    );

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/ttcs_ctrl.sv */
module ttcs_ctrl
    import ttcs_pkg::*;
    (
        input  logic         aclk,
        input  logic         aresetn,
        input  logic         s_tvalid,
        output logic         s_tready,
        input  ttcs_status_t status,
        output ttcs_cmd_t    cmd
    );

    localparam logic [3:0] ST_INIT_START = 4'd0;
    localparam logic [3:0] ST_INIT_WAIT  = 4'd1;
    localparam logic [3:0] ST_IDLE       = 4'd2;
    localparam logic [3:0] ST_EXEC       = 4'd3;
    localparam logic [3:0] ST_BS_WRITE   = 4'd4;
    localparam logic [3:0] ST_NEXT_ROW   = 4'd5;
    localparam logic [3:0] ST_SWEEP_WAIT = 4'd6;
    localparam logic [3:0] ST_READ_CAP   = 4'd7;
    localparam logic [3:0] ST_DONE       = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            ST_INIT_START: begin
                cmd.sweep_start = 1'b1;
                cmd.sweep_mode  = SWEEP_INIT;
                state_next      = ST_INIT_WAIT;
            end
            ST_INIT_WAIT: begin
                if (!status.sweep_busy) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.in_load = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (status.kind)
                    KIND_PUT: begin
                        cmd.put = 1'b1;
                        if (status.is_bs) begin
                            state_next = ST_BS_WRITE;
                        end else if (status.is_nl || status.col_last) begin
                            state_next = ST_NEXT_ROW;
                        end else begin
                            state_next = ST_DONE;
                        end
                    end
                    KIND_CLEAR: begin
                        cmd.home        = 1'b1;
                        cmd.sweep_start = 1'b1;
                        cmd.sweep_mode  = SWEEP_CLEAR;
                        state_next      = ST_SWEEP_WAIT;
                    end
                    KIND_READ: begin
                        cmd.read_issue = 1'b1;
                        state_next     = ST_READ_CAP;
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_BS_WRITE: begin
                cmd.bs_write = 1'b1;
                state_next   = ST_DONE;
            end
            ST_NEXT_ROW: begin
                cmd.next_row = 1'b1;
                if (status.row_last) begin
                    cmd.sweep_start = 1'b1;
                    cmd.sweep_mode  = SWEEP_SCROLL;
                    state_next      = ST_SWEEP_WAIT;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_SWEEP_WAIT: begin
                if (!status.sweep_busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_READ_CAP: begin
                cmd.cell_capture = 1'b1;
                state_next       = ST_DONE;
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT_START;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/ttcs_datapath.sv */
module ttcs_datapath
    import ttcs_pkg::*;
    #(
        parameter int COLUMNS = 80,
        parameter int ROWS = 25
    )
    (
        input  logic                  aclk,
        input  logic                  aresetn,
        input  ttcs_cmd_t             cmd,
        output ttcs_status_t          status,
        input  logic [S_DATA_W-1:0]   s_tdata,
        input  logic [KIND_W-1:0]     s_tuser,
        input  logic                  cfg_we,
        input  logic [CFG_IDX_W-1:0]  cfg_index,
        input  logic [CFG_DATA_W-1:0] cfg_data,
        output logic                  m_tvalid,
        input  logic                  m_tready,
        output logic [M_DATA_W-1:0]   m_tdata
    );

    localparam int TOTAL  = ROWS * COLUMNS;
    localparam int SCROLL = (ROWS - 1) * COLUMNS;
    localparam int ADDR_W = $clog2(TOTAL);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(TOTAL - 1);

    // Item register.
    logic [KIND_W-1:0]   in_kind_reg;
    logic [CHAR_W-1:0]   in_char_reg;
    logic [IN_ROW_W-1:0] in_row_reg;
    logic [IN_COL_W-1:0] in_col_reg;

    // Colors and cursor.
    logic [3:0]       fg_reg, fg_next;
    logic [3:0]       bg_reg, bg_next;
    logic [ROW_W-1:0] cur_row_reg, cur_row_next;
    logic [COL_W-1:0] cur_col_reg, cur_col_next;
    logic [7:0]       attr;

    // Sweep engine: each read is issued in the cycle before the write it feeds.
    logic              sw_active_reg, sw_active_next;
    logic [ADDR_W-1:0] sw_cnt_reg, sw_cnt_next;
    logic              sw_scroll_reg, sw_scroll_next;
    logic [CELL_W-1:0] sw_blank_reg, sw_blank_next;
    logic              wr_pend_reg, wr_pend_next;
    logic [ADDR_W-1:0] wr_addr_reg, wr_addr_next;
    logic              wr_src_ram_reg, wr_src_ram_next;
    logic              sw_in_copy;

    // Cell read and result.
    logic              rd_ok_reg;
    logic [CELL_W-1:0] cell_reg;
    logic              out_valid_reg, out_valid_next;
    logic [M_DATA_W-1:0] out_data_reg;

    // Memory ports.
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    logic              is_bs, is_nl;
    logic              rd_ok;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] cur_addr;
    logic [31:0]       row_wide;
    logic [31:0]       col_wide;

    assign attr  = {bg_reg, fg_reg};
    assign is_bs = (in_char_reg == CHAR_BACKSPACE);
    assign is_nl = (in_char_reg == CHAR_NEWLINE);

    assign rd_ok   = (32'(in_row_reg) < ROWS) && (32'(in_col_reg) < COLUMNS);
    assign rd_addr = rd_ok ? ADDR_W'(32'(in_row_reg) * COLUMNS + 32'(in_col_reg))
                           : '0;
    assign cur_addr = ADDR_W'(32'(cur_row_reg) * COLUMNS + 32'(cur_col_reg));
    assign sw_in_copy = sw_scroll_reg && (32'(sw_cnt_reg) < SCROLL);

    assign status.kind       = in_kind_reg;
    assign status.is_bs      = is_bs;
    assign status.is_nl      = is_nl;
    assign status.col_last   = (cur_col_reg == COL_LAST);
    assign status.row_last   = (cur_row_reg == ROW_LAST);
    assign status.sweep_busy = sw_active_reg || wr_pend_reg;
    assign status.out_free   = !out_valid_reg || m_tready;

    // Configuration and cursor.
    always_comb begin
        fg_next      = fg_reg;
        bg_next      = bg_reg;
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_FG_COLOR: fg_next = cfg_data;
                CFG_BG_COLOR: bg_next = cfg_data;
                default: begin
                end
            endcase
        end
        if (cmd.put) begin
            if (is_bs) begin
                if (cur_col_reg != '0) begin
                    cur_col_next = cur_col_reg - 1'b1;
                end else if (cur_row_reg != '0) begin
                    cur_col_next = COL_LAST;
                    cur_row_next = cur_row_reg - 1'b1;
                end
            end else if (!is_nl && !status.col_last) begin
                cur_col_next = cur_col_reg + 1'b1;
            end
        end
        if (cmd.next_row) begin
            cur_col_next = '0;
            if (!status.row_last) begin
                cur_row_next = cur_row_reg + 1'b1;
            end
        end
        if (cmd.home) begin
            cur_row_next = '0;
            cur_col_next = '0;
        end
    end

    // Sweep engine covering reset fill, clear and scroll.
    always_comb begin
        sw_active_next  = sw_active_reg;
        sw_cnt_next     = sw_cnt_reg;
        sw_scroll_next  = sw_scroll_reg;
        sw_blank_next   = sw_blank_reg;
        wr_pend_next    = 1'b0;
        wr_addr_next    = sw_cnt_reg;
        wr_src_ram_next = sw_in_copy;
        if (sw_active_reg) begin
            wr_pend_next = 1'b1;
            if (sw_cnt_reg == ADDR_LAST) begin
                sw_active_next = 1'b0;
            end else begin
                sw_cnt_next = sw_cnt_reg + 1'b1;
            end
        end
        if (cmd.sweep_start) begin
            sw_active_next = 1'b1;
            sw_cnt_next    = '0;
            sw_scroll_next = (cmd.sweep_mode == SWEEP_SCROLL);
            if (cmd.sweep_mode == SWEEP_INIT) begin
                sw_blank_next = {RESET_ATTR, CHAR_SPACE};
            end else begin
                sw_blank_next = {attr, CHAR_SPACE};
            end
        end
    end

    // Memory port selection.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = cur_addr;
        ram_wdata = {attr, CHAR_SPACE};
        if (wr_pend_reg) begin
            ram_we    = 1'b1;
            ram_waddr = wr_addr_reg;
            ram_wdata = wr_src_ram_reg ? ram_rdata : sw_blank_reg;
        end else if (cmd.put && !is_bs && !is_nl) begin
            ram_we    = 1'b1;
            ram_wdata = {attr, in_char_reg};
        end else if (cmd.bs_write) begin
            ram_we = 1'b1;
        end
        if (sw_active_reg) begin
            ram_raddr = ADDR_W'(32'(sw_cnt_reg) + COLUMNS);
        end else begin
            ram_raddr = rd_addr;
        end
    end

    assign out_valid_next = cmd.out_load ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    assign row_wide = 32'(cur_row_reg);
    assign col_wide = 32'(cur_col_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fg_reg        <= RESET_FG;
            bg_reg        <= RESET_BG;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            sw_active_reg <= 1'b0;
            wr_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            fg_reg        <= fg_next;
            bg_reg        <= bg_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            sw_active_reg <= sw_active_next;
            wr_pend_reg   <= wr_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sw_cnt_reg     <= sw_cnt_next;
        sw_scroll_reg  <= sw_scroll_next;
        sw_blank_reg   <= sw_blank_next;
        wr_addr_reg    <= wr_addr_next;
        wr_src_ram_reg <= wr_src_ram_next;
        if (cmd.in_load) begin
            in_kind_reg <= s_tuser;
            in_char_reg <= s_tdata[7:0];
            in_row_reg  <= s_tdata[12:8];
            in_col_reg  <= s_tdata[19:13];
            cell_reg    <= '0;
        end
        if (cmd.read_issue) begin
            rd_ok_reg <= rd_ok;
        end
        if (cmd.cell_capture) begin
            cell_reg <= rd_ok_reg ? ram_rdata : '0;
        end
        if (cmd.out_load) begin
            out_data_reg <= {4'd0, col_wide[IN_COL_W-1:0], row_wide[IN_ROW_W-1:0],
                             cell_reg[15:8], cell_reg[7:0]};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    ttcs_ram #(
        .WIDTH(CELL_W),
        .DEPTH(TOTAL)
    ) u_screen (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

endmodule

/* rtl/text_terminal_cursor_scroll.sv */
// Character-cell text terminal with a ROWS x COLUMNS screen store and a cursor.
// Items arrive on the s_ stream: s_tuser holds the kind (put character, clear,
// read cell), s_tdata the character and the cell to read. Each item gives
// exactly one transfer on the m_ stream with the read cell (zero unless a read)
// and the cursor position after the item.
// The block works on one item at a time. The cost of a scroll or a clear is set
// by the single write port of the screen memory, which the sweep walks one cell
// per cycle.
// The result sits in an output register, so the next item is taken while a
// result waits; a stalled receiver holds the block only once the following
// item is finished.
// After reset a fill pass writes blank cells with attribute 0x07 to the whole
// store with s_tready low. Color registers are written on the cfg_ channel
// (index 0 foreground, 1 background, others ignored); the user must write them
// only while the block is idle, which it does not enforce. cfg_ready is always high.
module text_terminal_cursor_scroll
    import ttcs_pkg::*;
    #(
        parameter int COLUMNS = 80,
        parameter int ROWS = 25
    )
    (
        input  logic                  aclk,
        input  logic                  aresetn,
        input  logic                  s_tvalid,
        output logic                  s_tready,
        // char_code[7:0], read_row[12:8], read_col[19:13], zero fill
        input  logic [S_DATA_W-1:0]   s_tdata,
        // kind[1:0]
        input  logic [KIND_W-1:0]     s_tuser,
        output logic                  m_tvalid,
        input  logic                  m_tready,
        // cell_char[7:0], cell_attr[15:8], cursor_row[20:16], cursor_col[27:21],
        // zero fill
        output logic [M_DATA_W-1:0]   m_tdata,
        input  logic                  cfg_valid,
        output logic                  cfg_ready,
        input  logic [CFG_IDX_W-1:0]  cfg_index,
        input  logic [CFG_DATA_W-1:0] cfg_data
    );

    ttcs_cmd_t    cmd;
    ttcs_status_t status;

    assign cfg_ready = 1'b1;

    ttcs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .status  (status),
        .cmd     (cmd)
    );

    ttcs_datapath #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg_we   (cfg_valid),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import ttcs_pkg::*;

    localparam int COLS = 80;
    localparam int ROWS = 25;
    localparam int NUM_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 210;
    localparam int LONG_HOLD = 300;
    localparam longint LIMIT_NS = 200_000_000;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
        logic [4:0] row;
        logic [6:0] col;
    } term_item_t;

    typedef struct packed {
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
        logic [4:0] cursor_row;
        logic [6:0] cursor_col;
    } term_result_t;

    typedef struct packed {
        term_item_t   item;
        logic         known;
        term_result_t res;
    } stim_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    // char_code[7:0], read_row[12:8], read_col[19:13], zero fill
    logic [S_DATA_W-1:0]   s_tdata;
    // kind[1:0]
    logic [KIND_W-1:0]     s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    // cell_char[7:0], cell_attr[15:8], cursor_row[20:16], cursor_col[27:21], zero fill
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Shadow copy of the screen, cursor and colors.
    logic [7:0] shadow_char [ROWS][COLS];
    logic [7:0] shadow_attr [ROWS][COLS];
    int         shadow_row;
    int         shadow_col;
    logic [3:0] fg_color;
    logic [3:0] bg_color;

    term_result_t cell_results_q[$];
    int           mismatches;
    bit           quiet;
    int           hold_requests;

    text_terminal_cursor_scroll #(
        .COLUMNS(COLS),
        .ROWS(ROWS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #(LIMIT_NS);
        $display("FAIL text_terminal_cursor_scroll");
        $finish;
    end

    // Moves the cursor to column 0 of the next row; at the bottom the whole
    // screen moves up one row and the last row is blanked.
    function automatic void line_feed();
        int r;
        int c;
        shadow_col = 0;
        if (shadow_row + 1 >= ROWS) begin
            for (r = 0; r < ROWS - 1; r++) begin
                for (c = 0; c < COLS; c++) begin
                    shadow_char[r][c] = shadow_char[r+1][c];
                    shadow_attr[r][c] = shadow_attr[r+1][c];
                end
            end
            for (c = 0; c < COLS; c++) begin
                shadow_char[ROWS-1][c] = CHAR_SPACE;
                shadow_attr[ROWS-1][c] = {bg_color, fg_color};
            end
            shadow_row = ROWS - 1;
        end else begin
            shadow_row++;
        end
    endfunction

    function automatic term_result_t terminal_apply(term_item_t it);
        term_result_t res;
        logic [7:0]   attr;
        int           r;
        int           c;
        res = '0;
        attr = {bg_color, fg_color};
        case (it.kind)
            KIND_PUT: begin
                if (it.ch == CHAR_BACKSPACE) begin
                    if (shadow_col > 0) begin
                        shadow_col--;
                    end else if (shadow_row > 0) begin
                        shadow_col = COLS - 1;
                        shadow_row--;
                    end
                    shadow_char[shadow_row][shadow_col] = CHAR_SPACE;
                    shadow_attr[shadow_row][shadow_col] = attr;
                end else if (it.ch == CHAR_NEWLINE) begin
                    line_feed();
                end else begin
                    shadow_char[shadow_row][shadow_col] = it.ch;
                    shadow_attr[shadow_row][shadow_col] = attr;
                    shadow_col++;
                    if (shadow_col >= COLS) line_feed();
                end
            end
            KIND_CLEAR: begin
                for (r = 0; r < ROWS; r++) begin
                    for (c = 0; c < COLS; c++) begin
                        shadow_char[r][c] = CHAR_SPACE;
                        shadow_attr[r][c] = attr;
                    end
                end
                shadow_row = 0;
                shadow_col = 0;
            end
            KIND_READ: begin
                if (it.row < ROWS && it.col < COLS) begin
                    res.cell_char = shadow_char[it.row][it.col];
                    res.cell_attr = shadow_attr[it.row][it.col];
                end
            end
            default: ;
        endcase
        res.cursor_row = 5'(shadow_row);
        res.cursor_col = 7'(shadow_col);
        return res;
    endfunction

    function automatic stim_row_t stim_row(logic [1:0] kind, logic [7:0] ch,
                                           logic [4:0] row, logic [6:0] col,
                                           logic known, logic [7:0] exp_char,
                                           logic [7:0] exp_attr, logic [4:0] exp_row,
                                           logic [6:0] exp_col);
        stim_row_t sr;
        sr.item = '{kind: kind, ch: ch, row: row, col: col};
        sr.known = known;
        sr.res = '{cell_char: exp_char, cell_attr: exp_attr,
                   cursor_row: exp_row, cursor_col: exp_col};
        return sr;
    endfunction

    // Offers one item, waits for its transfer and records what it should return.
    // A known result stands in for the prediction, which still updates the shadow.
    task automatic send_item(input term_item_t it, input logic known,
                             input term_result_t given);
        term_result_t predicted;
        int           gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.kind;
        s_tdata  <= {4'b0, it.col, it.row, it.ch};
        do @(posedge aclk); while (!s_tready);
        predicted = terminal_apply(it);
        cell_results_q.push_back(known ? given : predicted);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (cell_results_q.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_FG_COLOR) fg_color = val;
        else if (idx == CFG_BG_COLOR) bg_color = val;
        @(posedge aclk);
    endtask

    // Result side: checks each transfer and stalls in short random bursts,
    // or for a long stretch when the stimulus asks for one.
    initial begin
        term_result_t got;
        term_result_t want;
        int           stall_left;
        int           hold_left;
        int           holds_seen;
        stall_left = 0;
        hold_left = 0;
        holds_seen = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got.cell_char  = m_tdata[7:0];
                got.cell_attr  = m_tdata[15:8];
                got.cursor_row = m_tdata[20:16];
                got.cursor_col = m_tdata[27:21];
                if (cell_results_q.size() == 0) begin
                    $error("result transfer with no item pending: %h", m_tdata);
                    mismatches++;
                end else begin
                    want = cell_results_q.pop_front();
                    if (got.cell_char !== want.cell_char) begin
                        $error("cell_char expected %0h actual %0h",
                               want.cell_char, got.cell_char);
                        mismatches++;
                    end
                    if (got.cell_attr !== want.cell_attr) begin
                        $error("cell_attr expected %0h actual %0h",
                               want.cell_attr, got.cell_attr);
                        mismatches++;
                    end
                    if (got.cursor_row !== want.cursor_row) begin
                        $error("cursor_row expected %0d actual %0d",
                               want.cursor_row, got.cursor_row);
                        mismatches++;
                    end
                    if (got.cursor_col !== want.cursor_col) begin
                        $error("cursor_col expected %0d actual %0d",
                               want.cursor_col, got.cursor_col);
                        mismatches++;
                    end
                end
            end
            if (holds_seen != hold_requests) begin
                holds_seen++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 4) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        stim_row_t  directed_rows[$];
        stim_row_t  dr;
        term_item_t it;
        int         p;
        int         n;
        int         k;
        int         len;
        int         sel;
        int         r;
        int         c;
        bit         mid_done;
        logic [3:0] fg_val;
        logic [3:0] bg_val;

        mismatches = 0;
        quiet = 1'b0;
        hold_requests = 0;
        for (r = 0; r < ROWS; r++) begin
            for (c = 0; c < COLS; c++) begin
                shadow_char[r][c] = CHAR_SPACE;
                shadow_attr[r][c] = RESET_ATTR;
            end
        end
        shadow_row = 0;
        shadow_col = 0;
        fg_color = RESET_FG;
        bg_color = RESET_BG;

        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset contents, reads outside the screen, backspace at home, line wrap,
        // backspace across a row boundary, the unused kind and clear.
        directed_rows.push_back(stim_row(KIND_READ, 8'h00, 0, 0, 1, CHAR_SPACE, RESET_ATTR, 0, 0));
        directed_rows.push_back(stim_row(KIND_READ, 8'hFF, 24, 79, 1, CHAR_SPACE, RESET_ATTR, 0, 0));
        directed_rows.push_back(stim_row(KIND_READ, 8'h00, 25, 0, 1, 8'h00, 8'h00, 0, 0));
        directed_rows.push_back(stim_row(KIND_READ, 8'h00, 0, 80, 1, 8'h00, 8'h00, 0, 0));
        directed_rows.push_back(stim_row(KIND_READ, 8'h00, 31, 127, 1, 8'h00, 8'h00, 0, 0));
        directed_rows.push_back(stim_row(KIND_PUT, CHAR_BACKSPACE, 0, 0, 1, 8'h00, 8'h00, 0, 0));
        directed_rows.push_back(stim_row(KIND_READ, 8'h00, 0, 0, 1, CHAR_SPACE, RESET_ATTR, 0, 0));
        directed_rows.push_back(stim_row(KIND_PUT, 8'h41, 0, 0, 1, 8'h00, 8'h00, 0, 1));
        directed_rows.push_back(stim_row(KIND_PUT, 8'hFF, 31, 127, 1, 8'h00, 8'h00, 0, 2));
        directed_rows.push_back(stim_row(KIND_PUT, 8'h00, 0, 0, 1, 8'h00, 8'h00, 0, 3));
        directed_rows.push_back(stim_row(KIND_READ, 8'h00, 0, 1, 1, 8'hFF, RESET_ATTR, 0, 3));
        directed_rows.push_back(stim_row(KIND_READ, 8'h00, 0, 2, 1, 8'h00, RESET_ATTR, 0, 3));
        directed_rows.push_back(stim_row(KIND_PUT, CHAR_BACKSPACE, 0, 0, 1, 8'h00, 8'h00, 0, 2));
        directed_rows.push_back(stim_row(KIND_READ, 8'h00, 0, 2, 1, CHAR_SPACE, RESET_ATTR, 0, 2));
        directed_rows.push_back(stim_row(KIND_PUT, CHAR_NEWLINE, 0, 0, 1, 8'h00, 8'h00, 1, 0));
        directed_rows.push_back(stim_row(KIND_PUT, CHAR_BACKSPACE, 0, 0, 1, 8'h00, 8'h00, 0, 79));
        directed_rows.push_back(stim_row(KIND_PUT, 8'h7E, 0, 0, 1, 8'h00, 8'h00, 1, 0));
        directed_rows.push_back(stim_row(KIND_READ, 8'h00, 0, 79, 1, 8'h7E, RESET_ATTR, 1, 0));
        directed_rows.push_back(stim_row(KIND_UNUSED, 8'hAA, 31, 127, 1, 8'h00, 8'h00, 1, 0));
        directed_rows.push_back(stim_row(KIND_CLEAR, 8'h00, 0, 0, 1, 8'h00, 8'h00, 0, 0));
        directed_rows.push_back(stim_row(KIND_READ, 8'h00, 0, 1, 1, CHAR_SPACE, RESET_ATTR, 0, 0));
        directed_rows.push_back(stim_row(KIND_PUT, CHAR_NEWLINE, 0, 0, 1, 8'h00, 8'h00, 1, 0));
        directed_rows.push_back(stim_row(KIND_PUT, 8'h80, 16, 64, 0, '0, '0, '0, '0));
        directed_rows.push_back(stim_row(KIND_READ, 8'h55, 1, 0, 0, '0, '0, '0, '0));
        foreach (directed_rows[i]) begin
            dr = directed_rows[i];
            send_item(dr.item, dr.known, dr.res);
        end

        for (p = 0; p < NUM_PHASES; p++) begin
            drain_results();
            case (p)
                0: begin fg_val = 4'd15; bg_val = 4'd15; end
                1: begin fg_val = 4'd0;  bg_val = 4'd0;  end
                2: begin fg_val = 4'd0;  bg_val = 4'd15; end
                3: begin fg_val = 4'd15; bg_val = 4'd0;  end
                NUM_PHASES - 1: begin fg_val = RESET_FG; bg_val = RESET_BG; end
                default: begin
                    fg_val = $urandom_range(0, 15);
                    bg_val = $urandom_range(0, 15);
                end
            endcase
            write_reg(CFG_FG_COLOR, fg_val);
            write_reg(CFG_BG_COLOR, bg_val);
            // Indexes past the two colors must leave both untouched.
            write_reg($urandom_range(CFG_BG_COLOR + 1, 15), $urandom_range(0, 15));
            if (p == NUM_PHASES - 1) quiet = 1'b1;
            mid_done = 1'b0;
            n = 0;
            while (n < ITEMS_PER_PHASE) begin
                if (!mid_done && n >= ITEMS_PER_PHASE / 2) begin
                    mid_done = 1'b1;
                    if (p == 1) hold_requests++;
                    else if (p == 3) drain_results();
                end
                it.kind = KIND_PUT;
                it.ch   = $urandom_range(0, 255);
                it.row  = $urandom_range(0, 31);
                it.col  = $urandom_range(0, 127);
                sel = $urandom_range(0, 99);
                len = 1;
                if (sel < 55) begin
                    // printable code as drawn
                end else if (sel < 63) begin
                    it.ch = CHAR_NEWLINE;
                end else if (sel < 70) begin
                    it.ch = CHAR_BACKSPACE;
                    // Now and then a long run of backspaces walks back over rows.
                    if (sel >= 68) len = $urandom_range(2, 90);
                end else if (sel < 71) begin
                    it.kind = KIND_CLEAR;
                end else if (sel < 88) begin
                    it.kind = KIND_READ;
                    it.row  = (shadow_row > 0 && $urandom_range(0, 1)) ?
                              shadow_row - 1 : shadow_row;
                    it.col  = $urandom_range(0, COLS - 1);
                end else if (sel < 95) begin
                    it.kind = KIND_READ;
                    it.row  = $urandom_range(0, ROWS - 1);
                    it.col  = $urandom_range(0, COLS - 1);
                end else if (sel < 98) begin
                    it.kind = KIND_READ;
                end else begin
                    it.kind = KIND_UNUSED;
                end
                for (k = 0; k < len; k++) send_item(it, 1'b0, '0);
                n += len;
            end
        end

        drain_results();
        repeat (ROWS * COLS + 16) @(posedge aclk);
        if (mismatches == 0) begin
            $display("PASS text_terminal_cursor_scroll");
        end else begin
            $display("FAIL text_terminal_cursor_scroll");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/ttcs_pkg.sv
rtl/ttcs_ram.sv
rtl/ttcs_ctrl.sv
rtl/ttcs_datapath.sv
rtl/text_terminal_cursor_scroll.sv
sim/tb_top.sv
